// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the dither unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EDPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EDPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/edpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Types, sizes and arithmetic helpers for the palette dither block.
// ----------------------------------------------------------------------------
package edpd_pkg;

  localparam int unsigned LINE_MAX     = 2048;
  localparam int unsigned PALETTE_SIZE = 4096;
  localparam int unsigned MAP_DEPTH    = 32768;
  localparam int unsigned LB_DEPTH     = LINE_MAX + 1;
  localparam int unsigned LB_AW        = $clog2(LB_DEPTH);
  localparam int unsigned PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int unsigned MAP_AW       = $clog2(MAP_DEPTH);

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_EOL   = 2'd1,
    REQ_MAP   = 2'd2,
    REQ_PAL   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD2,
    ST_RD3,
    ST_CALC,
    ST_WR2,
    ST_OVF
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] load_address;
    logic [11:0] load_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_index;
    logic [10:0] pixel_column;
    logic        overflow;
  } out_item_t;

  typedef logic signed [10:0] err_t;

  typedef struct packed {
    err_t r;
    err_t g;
    err_t b;
  } err_entry_t;

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] res;
    if (v > 12'sd255) res = 8'd255;
    else if (v < 12'sd0) res = 8'd0;
    else res = v[7:0];
    return res;
  endfunction

  // Saturating add of a stored component and a diffused share.
  function automatic err_t sat_add(input err_t a, input err_t b);
    logic signed [11:0] s;
    err_t res;
    s = 12'(a) + 12'(b);
    if (s > 12'sd1023) res = 11'sd1023;
    else if (s < -12'sd1024) res = -11'sd1024;
    else res = s[10:0];
    return res;
  endfunction

  // Three eighths of the error, truncated toward zero.
  function automatic err_t three_eighths(input logic signed [9:0] e);
    logic signed [10:0] x;
    logic signed [10:0] res;
    x = (11'(e) <<< 1) + 11'(e);
    if (x < 11'sd0) res = (x + 11'sd7) >>> 3;
    else res = x >>> 3;
    return res;
  endfunction

  // One quarter of the error, truncated toward zero.
  function automatic err_t quarter(input logic signed [9:0] e);
    logic signed [10:0] x;
    logic signed [10:0] res;
    x = 11'(e);
    if (x < 11'sd0) res = (x + 11'sd3) >>> 2;
    else res = x >>> 2;
    return res;
  endfunction

endpackage

// ----- rtl/edpd_ram.sv -----
// ----------------------------------------------------------------------------
// Simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module edpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/error_diffusion_palette_dither_unit.sv -----
// ----------------------------------------------------------------------------
// Error diffusion palette dither unit
// Maps RGB pixels onto a loaded palette with three-neighbor error diffusion.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall/in_data: pixels, end of line, colour
//   map loads and palette loads. A transfer happens when valid is high and
//   stall is low. Each pixel gives one result transfer on out_valid/
//   out_stall/out_data; other requests give none.
//   A pixel goes from its transfer to its result through RD2, RD3, CALC
//   and WR2: two line buffer reads, the dependent map read, the palette
//   read and two write-backs, each memory having one read and one write
//   port. No request is taken until a pixel is done. A pixel beyond the
//   line store goes through ST_OVF and returns overflow set. After reset
//   both line buffers are cleared, one entry per cycle for all
//   LINE_MAX+1 = 2049 entries, while in_stall is held high. The result
//   sits in an output register; the next request is taken while it waits.
//   A pixel that finishes while out_stall holds the previous result waits
//   in its last state until the register frees.
module error_diffusion_palette_dither_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  edpd_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output edpd_pkg::out_item_t out_data
);
  import edpd_pkg::*;

`include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic [LB_AW-1:0] clr_r, clr_nxt;
  logic [LB_AW-1:0] column_r, column_nxt;
  logic [LB_AW-1:0] col_r, col_nxt;
  logic line_sel_r, line_sel_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [7:0] px_r_r, px_g_r, px_b_r;
  logic [7:0] sum_r_r, sum_g_r, sum_b_r;
  err_entry_t nxt_c_r, cur_c1_r;
  logic [11:0] idx_r;
  err_entry_t three_r, quart_r;

  logic accept, out_busy;
  logic [7:0] s_r, s_g, s_b;
  logic signed [9:0] e_r, e_g, e_b;
  logic [14:0] pal_col;
  err_entry_t three_c;

  // Logical line buffer ports, mapped to physical buffers by line_sel_r.
  logic cur_we, nxt_we;
  logic [LB_AW-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
  err_entry_t cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
  logic lb0_we, lb1_we;
  logic [LB_AW-1:0] lb0_waddr, lb1_waddr, lb0_raddr, lb1_raddr;
  logic [$bits(err_entry_t)-1:0] lb0_wdata, lb1_wdata, lb0_rdata, lb1_rdata;

  logic map_we;
  logic [MAP_AW-1:0] map_raddr;
  logic [11:0] map_rdata;
  logic pal_we;
  logic [PAL_AW-1:0] pal_raddr;
  logic [14:0] pal_wdata, pal_rdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_busy = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_rdata = line_sel_r ? err_entry_t'(lb1_rdata) : err_entry_t'(lb0_rdata);
  assign nxt_rdata = line_sel_r ? err_entry_t'(lb0_rdata) : err_entry_t'(lb1_rdata);

  // Pixel sum against the carried error of this column.
  assign s_r = clamp_byte(12'(cur_rdata.r) + $signed({4'b0, px_r_r}));
  assign s_g = clamp_byte(12'(cur_rdata.g) + $signed({4'b0, px_g_r}));
  assign s_b = clamp_byte(12'(cur_rdata.b) + $signed({4'b0, px_b_r}));

  assign pal_col = ({1'b0, idx_r} < 13'(PALETTE_SIZE)) ? pal_rdata : 15'd0;
  assign e_r = $signed({2'b0, sum_r_r}) - $signed({2'b0, pal_col[14:10], 3'b0});
  assign e_g = $signed({2'b0, sum_g_r}) - $signed({2'b0, pal_col[9:5], 3'b0});
  assign e_b = $signed({2'b0, sum_b_r}) - $signed({2'b0, pal_col[4:0], 3'b0});
  assign three_c = '{r: three_eighths(e_r), g: three_eighths(e_g), b: three_eighths(e_b)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      column_r    <= '0;
      line_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      column_r    <= column_nxt;
      line_sel_r  <= line_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    col_r      <= col_nxt;
    if (accept) begin
      px_r_r <= in_data.red;
      px_g_r <= in_data.green;
      px_b_r <= in_data.blue;
    end
    if (state_r == ST_RD2) begin
      sum_r_r <= s_r;
      sum_g_r <= s_g;
      sum_b_r <= s_b;
      nxt_c_r <= nxt_rdata;
    end
    if (state_r == ST_RD3) begin
      idx_r    <= map_rdata;
      cur_c1_r <= cur_rdata;
    end
    if (state_r == ST_CALC) begin
      three_r <= three_c;
      quart_r <= '{r: quarter(e_r), g: quarter(e_g), b: quarter(e_b)};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    column_nxt    = column_r;
    col_nxt       = col_r;
    line_sel_nxt  = line_sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cur_we        = 1'b0;
    nxt_we        = 1'b0;
    cur_waddr     = col_r;
    nxt_waddr     = col_r;
    cur_wdata     = '0;
    nxt_wdata     = '0;
    cur_raddr     = column_r;
    nxt_raddr     = column_r;
    unique case (state_r)
      ST_CLEAR: begin
        cur_we    = 1'b1;
        nxt_we    = 1'b1;
        cur_waddr = clr_r;
        nxt_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LB_AW'(LINE_MAX)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            REQ_EOL: begin
              // The old current line becomes the next line; clear its column 0.
              line_sel_nxt = !line_sel_r;
              column_nxt   = '0;
              cur_we       = 1'b1;
              cur_waddr    = '0;
            end
            REQ_PIXEL: begin
              col_nxt = column_r;
              if (column_r >= LB_AW'(LINE_MAX)) begin
                state_nxt = ST_OVF;
              end else begin
                state_nxt = ST_RD2;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD2: begin
        cur_raddr = col_r + 1'b1;
        state_nxt = ST_RD3;
      end
      ST_RD3: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cur_we    = 1'b1;
        cur_wdata = '{r: err_t'({3'b0, sum_r_r}), g: err_t'({3'b0, sum_g_r}),
                      b: err_t'({3'b0, sum_b_r})};
        nxt_we    = 1'b1;
        nxt_wdata = '{r: sat_add(nxt_c_r.r, three_c.r), g: sat_add(nxt_c_r.g, three_c.g),
                      b: sat_add(nxt_c_r.b, three_c.b)};
        state_nxt = ST_WR2;
      end
      ST_WR2: begin
        if (!out_busy) begin
          cur_we        = 1'b1;
          cur_waddr     = col_r + 1'b1;
          cur_wdata     = '{r: sat_add(cur_c1_r.r, three_r.r),
                            g: sat_add(cur_c1_r.g, three_r.g),
                            b: sat_add(cur_c1_r.b, three_r.b)};
          nxt_we        = 1'b1;
          nxt_waddr     = col_r + 1'b1;
          nxt_wdata     = quart_r;
          column_nxt    = col_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pixel_index: idx_r, pixel_column: col_r[10:0], overflow: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pixel_index: '0, pixel_column: '0, overflow: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign lb0_we    = line_sel_r ? nxt_we : cur_we;
  assign lb1_we    = line_sel_r ? cur_we : nxt_we;
  assign lb0_waddr = line_sel_r ? nxt_waddr : cur_waddr;
  assign lb1_waddr = line_sel_r ? cur_waddr : nxt_waddr;
  assign lb0_wdata = line_sel_r ? nxt_wdata : cur_wdata;
  assign lb1_wdata = line_sel_r ? cur_wdata : nxt_wdata;
  assign lb0_raddr = line_sel_r ? nxt_raddr : cur_raddr;
  assign lb1_raddr = line_sel_r ? cur_raddr : nxt_raddr;

  assign map_we    = accept && (in_data.req_type == REQ_MAP);
  assign map_raddr = {s_r[7:3], s_g[7:3], s_b[7:3]};
  assign pal_we    = accept && (in_data.req_type == REQ_PAL) &&
                     (in_data.load_address < 15'(PALETTE_SIZE));
  assign pal_wdata = {in_data.red[7:3], in_data.green[7:3], in_data.blue[7:3]};
  assign pal_raddr = map_rdata[PAL_AW-1:0];

  edpd_ram #(.WIDTH($bits(err_entry_t)), .DEPTH(LB_DEPTH)) u_line0 (
    .clk(clk), .we(lb0_we), .waddr(lb0_waddr), .wdata(lb0_wdata),
    .raddr(lb0_raddr), .rdata(lb0_rdata)
  );

  edpd_ram #(.WIDTH($bits(err_entry_t)), .DEPTH(LB_DEPTH)) u_line1 (
    .clk(clk), .we(lb1_we), .waddr(lb1_waddr), .wdata(lb1_wdata),
    .raddr(lb1_raddr), .rdata(lb1_rdata)
  );

  edpd_ram #(.WIDTH(12), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(in_data.load_address[MAP_AW-1:0]),
    .wdata(in_data.load_index), .raddr(map_raddr), .rdata(map_rdata)
  );

  edpd_ram #(.WIDTH(15), .DEPTH(PALETTE_SIZE)) u_pal (
    .clk(clk), .we(pal_we), .waddr(in_data.load_address[PAL_AW-1:0]),
    .wdata(pal_wdata), .raddr(pal_raddr), .rdata(pal_rdata)
  );

  `EDPD_ASSERT_IMP(a_busy_stalls, state_r != ST_IDLE, in_stall, "input taken while busy")
  `EDPD_ASSERT_NXT(a_wr2_out, (state_r == ST_WR2) && !out_busy, out_valid_r && !out_data_r.overflow, "pixel result lost")
  `EDPD_ASSERT_IMP(a_col_bound, state_r == ST_RD2, col_r < LB_AW'(LINE_MAX), "pixel beyond line store processed")

endmodule
